### sv/lcs_pkg.sv
// Shared types and constants of the life automaton stepper.
`default_nettype none
package lcs_pkg;

  localparam int CfgW = 7;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [3:0] SURVIVE_LO = 4'd2;
  localparam logic [3:0] BIRTH_CNT  = 4'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] col;
    logic [5:0] row;
    logic       alive_in;
  } in_item_t;

  typedef struct packed {
    logic alive_out;
    logic out_of_range;
  } out_item_t;

  typedef struct packed {
    logic            addr;
    logic [CfgW-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

  // Masked column slice of one cell: above, current and below row.
  typedef logic [2:0] nbr_t;

endpackage
`default_nettype wire

### sv/lcs_chan_if.sv
// Valid/ready channel interface carrying one payload item.
`default_nettype none
interface lcs_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/life_automaton_stepper.sv
// Top level of the life automaton stepper: control, board memory and cell chain.
//
//   channel  | dir | handshake    | payload
//   in_ch    | in  | valid/ready  | mode, col, row, alive_in
//   out_ch   | out | valid/ready  | alive_out, out_of_range
//   cfg_ch   | in  | valid/ready  | addr (0 width, 1 height), wdata
//
// A cell read or write passes through accept, row read and result load.
// An out-of-range access or an unused mode goes from accept straight to the finish step.
// An advance sweeps the rows of the board in order; the row sweep through the board memory
// reads one row and writes one row per cycle.
// Reset clears every row to dead through per-row valid bits, with no clearing pass.
// A new item is taken while an earlier result still waits on out_ch; the next
// result then waits in the finish step until out_ch takes the earlier one.
`default_nettype none
module life_automaton_stepper #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input wire logic    clk,
  input wire logic    rst_n,
  lcs_chan_if.sink    in_ch,
  lcs_chan_if.source  out_ch,
  lcs_chan_if.sink    cfg_ch
);

  localparam int AW   = $clog2(MAX_ROWS);
  localparam int CB   = $clog2(MAX_COLS);
  localparam int WW0  = $clog2(MAX_COLS + 1);
  localparam int WW   = (WW0 > lcs_pkg::CfgW) ? WW0 : lcs_pkg::CfgW;
  localparam int HW0  = $clog2(MAX_ROWS + 1);
  localparam int HW   = (HW0 > lcs_pkg::CfgW) ? HW0 : lcs_pkg::CfgW;
  localparam int SW   = $clog2(MAX_ROWS + 2);
  localparam int CNTW = (SW > HW) ? SW : HW;
  localparam int RIW  = (AW > 6) ? AW : 6;
  localparam int CIW  = (CB > 6) ? CB : 6;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ACC   = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [lcs_pkg::CfgW-1:0] cfg_w_r, cfg_w_nxt;
  logic [lcs_pkg::CfgW-1:0] cfg_h_r, cfg_h_nxt;
  logic [WW-1:0]            eff_w;
  logic [WW-1:0]            w_ext;
  logic [HW-1:0]            eff_h;
  logic [HW-1:0]            h_ext;

  logic [1:0]               mode_r, mode_nxt;
  logic [5:0]               col_r, col_nxt;
  logic [AW-1:0]            row_addr_r, row_addr_nxt;
  logic                     alive_r, alive_nxt;
  logic                     res_alive_r, res_alive_nxt;
  logic                     res_oor_r, res_oor_nxt;
  logic [SW-1:0]            s_r, s_nxt;
  logic                     rd_ok_r, rd_ok_nxt;
  logic [MAX_ROWS-1:0]      row_valid_r, row_valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  lcs_pkg::out_item_t       out_data_r, out_data_nxt;

  logic [RIW-1:0]           in_row_ext;
  logic [AW-1:0]            in_row_addr;
  logic [CIW-1:0]           col_ext;
  logic [CB-1:0]            col_idx;
  logic [CNTW-1:0]          s_ext;
  logic [CNTW-1:0]          h_cnt;
  logic [CNTW-1:0]          h_p1;
  logic [SW-1:0]            s_m2;
  logic                     in_xfer;
  logic                     in_oor;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [MAX_COLS-1:0]      ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [MAX_COLS-1:0]      ram_rdata;
  logic [MAX_COLS-1:0]      row_data;
  logic [MAX_COLS-1:0]      acc_row;
  logic [MAX_COLS-1:0]      next_row;
  lcs_pkg::nbr_t            nb [MAX_COLS];
  lcs_pkg::cell_ctl_t       cell_ctl;

  assign w_ext = WW'(cfg_w_r);
  assign eff_w = (w_ext > WW'(MAX_COLS)) ? WW'(MAX_COLS) : w_ext;
  assign h_ext = HW'(cfg_h_r);
  assign eff_h = (h_ext > HW'(MAX_ROWS)) ? HW'(MAX_ROWS) : h_ext;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_row_ext  = RIW'(in_ch.data.row);
  assign in_row_addr = in_row_ext[AW-1:0];
  assign in_oor      = (WW'(in_ch.data.col) >= eff_w) || (HW'(in_ch.data.row) >= eff_h);
  assign col_ext     = CIW'(col_r);
  assign col_idx     = col_ext[CB-1:0];
  assign s_ext       = CNTW'(s_r);
  assign h_cnt       = CNTW'(eff_h);
  assign h_p1        = h_cnt + CNTW'(1);
  assign s_m2        = s_r - SW'(2);

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign row_data = rd_ok_r ? ram_rdata : '0;

  always_comb begin
    acc_row          = row_data;
    acc_row[col_idx] = alive_r;
  end

  always_comb begin
    cfg_w_nxt = cfg_w_r;
    cfg_h_nxt = cfg_h_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.data.addr)
        lcs_pkg::REG_WIDTH:  cfg_w_nxt = cfg_ch.data.wdata;
        lcs_pkg::REG_HEIGHT: cfg_h_nxt = cfg_ch.data.wdata;
        default:             cfg_w_nxt = cfg_w_r;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    col_nxt       = col_r;
    row_addr_nxt  = row_addr_r;
    alive_nxt     = alive_r;
    res_alive_nxt = res_alive_r;
    res_oor_nxt   = res_oor_r;
    s_nxt         = s_r;
    rd_ok_nxt     = 1'b0;
    row_valid_nxt = row_valid_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = row_addr_r;
    ram_wdata     = acc_row;
    ram_raddr     = in_row_addr;
    cell_ctl      = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          mode_nxt      = in_ch.data.mode;
          col_nxt       = in_ch.data.col;
          row_addr_nxt  = in_row_addr;
          alive_nxt     = in_ch.data.alive_in;
          res_alive_nxt = 1'b0;
          res_oor_nxt   = 1'b0;
          if ((in_ch.data.mode == lcs_pkg::MODE_WRITE) ||
              (in_ch.data.mode == lcs_pkg::MODE_READ)) begin
            rd_ok_nxt   = row_valid_r[in_row_addr];
            res_oor_nxt = in_oor;
            state_nxt   = in_oor ? ST_FIN : ST_ACC;
          end else if (in_ch.data.mode == lcs_pkg::MODE_STEP) begin
            cell_ctl.clear = 1'b1;
            s_nxt          = '0;
            state_nxt      = ST_SWEEP;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_ACC: begin
        if (mode_r == lcs_pkg::MODE_WRITE) begin
          ram_we                    = 1'b1;
          row_valid_nxt[row_addr_r] = 1'b1;
        end else begin
          res_alive_nxt = row_data[col_idx];
        end
        state_nxt = ST_FIN;
      end
      ST_SWEEP: begin
        cell_ctl.shift = 1'b1;
        ram_raddr      = s_r[AW-1:0];
        rd_ok_nxt      = (s_ext < h_cnt) && row_valid_r[s_r[AW-1:0]];
        ram_waddr      = s_m2[AW-1:0];
        ram_wdata      = next_row;
        if (s_r >= SW'(2)) begin
          ram_we                      = 1'b1;
          row_valid_nxt[s_m2[AW-1:0]] = 1'b1;
        end
        s_nxt = s_r + SW'(1);
        if (s_ext == h_p1) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.alive_out    = res_alive_r;
          out_data_nxt.out_of_range = res_oor_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_w_r     <= lcs_pkg::CfgW'(64);
      cfg_h_r     <= lcs_pkg::CfgW'(64);
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
      rd_ok_r     <= 1'b0;
      s_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      cfg_w_r     <= cfg_w_nxt;
      cfg_h_r     <= cfg_h_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
      rd_ok_r     <= rd_ok_nxt;
      s_r         <= s_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    col_r       <= col_nxt;
    row_addr_r  <= row_addr_nxt;
    alive_r     <= alive_nxt;
    res_alive_r <= res_alive_nxt;
    res_oor_r   <= res_oor_nxt;
    out_data_r  <= out_data_nxt;
  end

  lcs_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_board (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    localparam logic [WW-1:0] CIDX = WW'(c);
    lcs_pkg::nbr_t left_nb;
    lcs_pkg::nbr_t right_nb;

    if (c == 0) begin : g_left_edge
      assign left_nb = '0;
    end else begin : g_left
      assign left_nb = nb[c-1];
    end
    if (c == MAX_COLS - 1) begin : g_right_edge
      assign right_nb = '0;
    end else begin : g_right
      assign right_nb = nb[c+1];
    end

    lcs_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl),
      .active    (CIDX < eff_w),
      .below_raw (row_data[c]),
      .left_nb   (left_nb),
      .right_nb  (right_nb),
      .own_nb    (nb[c]),
      .next_bit  (next_row[c])
    );
  end

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && ram_we && s_ext < h_cnt) |-> (ram_waddr != ram_raddr))
    else $error("Sweep writes the row it is reading.");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (s_ext <= h_p1))
    else $error("Sweep counter ran past the last row.");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("Result loaded outside the finish step.");

  a_acc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> !res_oor_r)
    else $error("Memory access for an out-of-range position.");

endmodule
`default_nettype wire

### sv/lcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lcs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### sv/lcs_cell.sv
// One column cell: holds the above and current rows of a three-row window and computes the next cell value.
`default_nettype none
module lcs_cell (
  input  wire logic              clk,
  input  wire lcs_pkg::cell_ctl_t ctl,
  input  wire logic              active,
  input  wire logic              below_raw,
  input  wire lcs_pkg::nbr_t     left_nb,
  input  wire lcs_pkg::nbr_t     right_nb,
  output lcs_pkg::nbr_t          own_nb,
  output logic                   next_bit
);

  logic       above_r;
  logic       above_nxt;
  logic       cur_r;
  logic       cur_nxt;
  logic       cur_m;
  logic [3:0] count;
  logic       alive;

  always_comb begin
    above_nxt = above_r;
    cur_nxt   = cur_r;
    priority if (ctl.clear) begin
      above_nxt = 1'b0;
      cur_nxt   = 1'b0;
    end else if (ctl.shift) begin
      above_nxt = cur_r;
      cur_nxt   = below_raw;
    end
  end

  always_ff @(posedge clk) begin
    above_r <= above_nxt;
    cur_r   <= cur_nxt;
  end

  assign cur_m  = cur_r & active;
  assign own_nb = {above_r & active, cur_m, below_raw & active};

  assign count = {3'b0, left_nb[0]} + {3'b0, left_nb[1]} + {3'b0, left_nb[2]}
               + {3'b0, right_nb[0]} + {3'b0, right_nb[1]} + {3'b0, right_nb[2]}
               + {3'b0, own_nb[0]} + {3'b0, own_nb[2]};

  assign alive = cur_m ? ((count == lcs_pkg::SURVIVE_LO) || (count == lcs_pkg::BIRTH_CNT))
                       : (count == lcs_pkg::BIRTH_CNT);

  // Cells right of the active width keep their old contents.
  assign next_bit = active ? alive : cur_r;

endmodule
`default_nettype wire
